[rtl/spsc_pkg.sv]
// ============================================================================
// spsc_pkg
// Shared types and constants of the slot pool stack channel.
// ============================================================================
package spsc_pkg;

    localparam int DEPTH_DEF   = 16;
    localparam int DATA_W_DEF  = 32;
    localparam int ITEM_W      = 32;
    localparam int CFG_W       = 5;
    localparam int SLOTS_RESET = 16;

    typedef enum logic [0:0] {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

endpackage

[rtl/spsc_if.sv]
// ============================================================================
// spsc_in_if / spsc_out_if
// Valid/ready channels for access requests and access results.
// ============================================================================
interface spsc_in_if;
    logic                              valid;
    logic                              ready;
    spsc_pkg::t_kind                   kind;
    logic [spsc_pkg::ITEM_W-1:0]       item_data;

    modport source (output valid, output kind, output item_data, input ready);
    modport sink   (input valid, input kind, input item_data, output ready);
endinterface

interface spsc_out_if;
    logic                              valid;
    logic                              ready;
    logic                              done_res;
    logic [spsc_pkg::ITEM_W-1:0]       read_data;
    logic                              woke_consumer;
    logic                              woke_producer;

    modport source (output valid, output done_res, output read_data,
                    output woke_consumer, output woke_producer, input ready);
    modport sink   (input valid, input done_res, input read_data,
                    input woke_consumer, input woke_producer, output ready);
endinterface

[rtl/spsc_ram.sv]
// ============================================================================
// spsc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
module spsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/slot_pool_stack_channel.sv]
// ============================================================================
// slot_pool_stack_channel
// Bounded LIFO channel of data slots kept on a free list and a used stack.
// ============================================================================
// A successful push or pop reads the link memory in the cycle the transaction
// is accepted, and the new head and the link write-back follow in the next
// cycle. A failed try on a full or empty channel writes its result straight
// into the output register. One access is in work at a time; the result
// waits there, and the next transaction is taken once that register is free or
// drains in the same cycle. Both lists share one link memory, since a slot is
// on at most one of them. Slots never handed out since the last slot count
// write are tracked by a fill counter, so neither reset nor a slot count write
// needs a clearing pass and both take effect at once.
module slot_pool_stack_channel #(
    parameter int DEPTH  = spsc_pkg::DEPTH_DEF,
    parameter int DATA_W = spsc_pkg::DATA_W_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [spsc_pkg::CFG_W-1:0] i_cfg_wdata,
    spsc_in_if.sink                    i_in,
    spsc_out_if.source                 o_out
);

    localparam int LINK_W = $clog2(DEPTH + 1);
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [LINK_W-1:0]   r_free_head, n_free_head;
    logic [LINK_W-1:0]   r_used_head, n_used_head;
    logic [LINK_W-1:0]   r_fill, n_fill;
    logic [LINK_W-1:0]   r_count, n_count;
    logic [LINK_W-1:0]   r_slot, n_slot;
    spsc_pkg::t_kind     r_kind, n_kind;
    logic                r_from_list, n_from_list;

    logic                r_out_valid, n_out_valid;
    logic                r_done, n_done;
    logic [spsc_pkg::ITEM_W-1:0] r_read_data, n_read_data;
    logic                r_woke_cons, n_woke_cons;
    logic                r_woke_prod, n_woke_prod;

    logic                in_fire;
    logic [LINK_W-1:0]   cfg_count;
    logic [LINK_W-1:0]   slot_a;
    logic [IDX_W-1:0]    raddr;
    logic                link_we;
    logic [IDX_W-1:0]    link_waddr;
    logic [LINK_W-1:0]   link_wdata;
    logic [LINK_W-1:0]   link_rdata;
    logic                data_we;
    logic [DATA_W-1:0]   data_rdata;

    assign i_in.ready = (r_state == ST_IDLE) && (!r_out_valid || o_out.ready);
    assign in_fire    = i_in.valid && i_in.ready;

    always_comb begin
        if (int'(i_cfg_wdata) > DEPTH) begin
            cfg_count = LINK_W'(DEPTH);
        end else begin
            cfg_count = LINK_W'(i_cfg_wdata);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_free_head = r_free_head;
        n_used_head = r_used_head;
        n_fill      = r_fill;
        n_count     = r_count;
        n_slot      = r_slot;
        n_kind      = r_kind;
        n_from_list = r_from_list;
        n_out_valid = r_out_valid && !o_out.ready;
        n_done      = r_done;
        n_read_data = r_read_data;
        n_woke_cons = r_woke_cons;
        n_woke_prod = r_woke_prod;
        slot_a      = '0;
        data_we     = 1'b0;
        link_we     = 1'b0;
        link_waddr  = IDX_W'(r_slot - 1'b1);
        link_wdata  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_kind = i_in.kind;
                    if (i_in.kind == spsc_pkg::KIND_PUSH) begin
                        if (r_free_head != '0) begin
                            slot_a      = r_free_head;
                            n_from_list = 1'b1;
                        end else if (r_fill < r_count) begin
                            slot_a      = r_fill + 1'b1;
                            n_fill      = r_fill + 1'b1;
                            n_from_list = 1'b0;
                        end
                        data_we = (slot_a != '0);
                    end else begin
                        slot_a = r_used_head;
                    end
                    n_slot = slot_a;
                    if (slot_a != '0) begin
                        n_state = ST_EXEC;
                    end else begin
                        n_out_valid = 1'b1;
                        n_done      = 1'b0;
                        n_read_data = '0;
                        n_woke_cons = 1'b0;
                        n_woke_prod = 1'b0;
                    end
                end
            end
            ST_EXEC: begin
                n_state     = ST_IDLE;
                link_we     = 1'b1;
                n_out_valid = 1'b1;
                n_done      = 1'b1;
                if (r_kind == spsc_pkg::KIND_PUSH) begin
                    if (r_from_list) begin
                        n_free_head = link_rdata;
                    end
                    link_wdata  = r_used_head;
                    n_used_head = r_slot;
                    n_read_data = '0;
                    n_woke_cons = (r_used_head == '0);
                    n_woke_prod = 1'b0;
                end else begin
                    n_used_head = link_rdata;
                    link_wdata  = r_free_head;
                    n_free_head = r_slot;
                    n_read_data = spsc_pkg::ITEM_W'(data_rdata);
                    n_woke_cons = 1'b0;
                    n_woke_prod = (r_free_head == '0) && (r_fill == r_count);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_count     = cfg_count;
            n_fill      = '0;
            n_free_head = '0;
            n_used_head = '0;
        end
    end

    assign raddr = IDX_W'(slot_a - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_free_head <= '0;
            r_used_head <= '0;
            r_fill      <= '0;
            r_count     <= (spsc_pkg::SLOTS_RESET > DEPTH) ? LINK_W'(DEPTH)
                                                          : LINK_W'(spsc_pkg::SLOTS_RESET);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_used_head <= n_used_head;
            r_fill      <= n_fill;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot      <= n_slot;
        r_kind      <= n_kind;
        r_from_list <= n_from_list;
        r_done      <= n_done;
        r_read_data <= n_read_data;
        r_woke_cons <= n_woke_cons;
        r_woke_prod <= n_woke_prod;
    end

    spsc_ram #(
        .WIDTH (LINK_W),
        .DEPTH (DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (raddr),
        .o_rdata (link_rdata)
    );

    spsc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (raddr),
        .i_wdata (DATA_W'(i_in.item_data)),
        .i_raddr (raddr),
        .o_rdata (data_rdata)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.done_res      = r_done;
    assign o_out.read_data     = r_read_data;
    assign o_out.woke_consumer = r_woke_cons;
    assign o_out.woke_producer = r_woke_prod;

endmodule
